// File: sv/bkt_pkg.sv
// Shared types and codes of the bucket table with overflow cut.
package bkt_pkg;

	localparam int BUCKET_W = 10;
	localparam int SLOT_W = 4;
	localparam int LIMIT_W = 5;
	localparam int COUNT_W = 5;
	localparam int ENTRY_W = 56;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_STORED = 3'd0,
		ST_CUT_NOW = 3'd1,
		ST_IGNORED = 3'd2,
		ST_READ_OK = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef struct packed {
		logic mode;
		logic [BUCKET_W-1:0] bucket;
		logic [SLOT_W-1:0] slot;
		logic [31:0] doc_id;
		logic [15:0] point_id;
		logic [7:0] quotient;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [COUNT_W-1:0] fill_count;
		logic is_cut;
		logic [31:0] read_doc;
		logic [15:0] read_point;
		logic [7:0] read_quotient;
	} rsp_t;

endpackage

// File: sv/bkt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/bkt_front.sv
// Front end: accepts items, reduces the bucket index and queues them for the back end.
module bkt_front #(
	parameter int NUM_BUCKETS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic clearing,
	input  logic req_valid,
	output logic req_ready,
	input  bkt_pkg::req_t req,
	output logic q_valid,
	input  logic q_ready,
	output bkt_pkg::req_t q_item,
	output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] q_idx
);

	localparam int BW = bkt_pkg::BUCKET_W;
	localparam int SH = 2 * BW;
	localparam int NB_W = $clog2(NUM_BUCKETS + 1);
	localparam int IDX_W = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
	localparam logic [SH-1:0] RECIP = SH'((2 ** SH) / NUM_BUCKETS);

	logic valid_s1;
	bkt_pkg::req_t item_s1;
	logic [BW-1:0] quo_s1;

	bkt_pkg::req_t fifo_item_q [2];
	logic [IDX_W-1:0] fifo_idx_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	logic [BW+SH-1:0] prod;
	logic [BW-1:0] quo_d;
	logic [BW+NB_W-1:0] qn;
	logic [BW-1:0] rem0;
	logic [BW-1:0] rem1;
	logic [IDX_W-1:0] idx_d;
	logic push;
	logic pop;
	logic accept;

	assign prod = (BW + SH)'(req.bucket) * (BW + SH)'(RECIP);
	assign quo_d = prod[BW+SH-1:SH];
	assign qn = (BW + NB_W)'(quo_s1) * (BW + NB_W)'(NUM_BUCKETS);
	assign rem0 = item_s1.bucket - qn[BW-1:0];
	assign rem1 = ((BW + NB_W)'(rem0) >= (BW + NB_W)'(NUM_BUCKETS)) ?
		rem0 - BW'(NUM_BUCKETS) : rem0;
	assign idx_d = IDX_W'(rem1);

	assign push = valid_s1 && (count_q != 2'd2);
	assign pop = q_valid && q_ready;
	assign req_ready = !clearing && (!valid_s1 || push);
	assign accept = req_valid && req_ready;

	assign q_valid = count_q != 2'd0;
	assign q_item = fifo_item_q[rd_ptr_q];
	assign q_idx = fifo_idx_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
			quo_s1 <= quo_d;
		end
		if (push) begin
			fifo_item_q[wr_ptr_q] <= item_s1;
			fifo_idx_q[wr_ptr_q] <= idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/bkt_back.sv
// Back end: bucket state and entry memories, per-item read-modify-write and result register.
module bkt_back #(
	parameter int NUM_BUCKETS = 1024,
	parameter int BUCKET_WAYS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bkt_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic q_valid,
	output logic q_ready,
	input  bkt_pkg::req_t q_item,
	input  logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] q_idx,
	output logic clearing,
	output logic rsp_valid,
	input  logic rsp_ready,
	output bkt_pkg::rsp_t rsp
);

	localparam int IDX_W = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
	localparam int FILL_W = $clog2(BUCKET_WAYS + 1);
	localparam int CMP_W = FILL_W + bkt_pkg::LIMIT_W;
	localparam int ENT_DEPTH = NUM_BUCKETS * BUCKET_WAYS;
	localparam int EA_W = ENT_DEPTH > 1 ? $clog2(ENT_DEPTH) : 1;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL,
		S_READ
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic [bkt_pkg::LIMIT_W-1:0] limit_q;
	bkt_pkg::req_t item_q;
	logic [IDX_W-1:0] idx_q;
	logic [EA_W-1:0] base_q;
	logic [FILL_W-1:0] fill_q;
	logic rsp_valid_q;
	bkt_pkg::rsp_t rsp_q;

	logic st_we;
	logic [IDX_W-1:0] st_waddr;
	logic [FILL_W:0] st_wdata;
	logic [FILL_W:0] st_rdata;
	logic ent_we;
	logic [EA_W-1:0] ent_waddr;
	logic [EA_W-1:0] ent_raddr;
	logic [bkt_pkg::ENTRY_W-1:0] ent_rdata;

	logic cur_cut;
	logic [FILL_W-1:0] cur_fill;
	logic [CMP_W-1:0] lim;
	logic cut_now;
	logic is_insert;
	logic slot_hit;

	assign cur_cut = st_rdata[FILL_W];
	assign cur_fill = st_rdata[FILL_W-1:0];
	assign lim = (CMP_W'(limit_q) < CMP_W'(BUCKET_WAYS)) ? CMP_W'(limit_q) : CMP_W'(BUCKET_WAYS);
	assign cut_now = (cur_fill != '0) && (CMP_W'(cur_fill) >= lim);
	assign is_insert = item_q.mode == bkt_pkg::MODE_INSERT;
	assign slot_hit = CMP_W'(item_q.slot) < CMP_W'(cur_fill);

	assign clearing = state_q == S_CLEAR;
	assign q_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		st_we = 1'b0;
		st_waddr = idx_q;
		st_wdata = '0;
		if (state_q == S_CLEAR) begin
			st_we = 1'b1;
			st_waddr = clr_cnt_q;
		end else if (state_q == S_EVAL && is_insert && !cur_cut) begin
			st_we = 1'b1;
			st_wdata = cut_now ? {1'b1, FILL_W'(0)} : {1'b0, cur_fill + FILL_W'(1)};
		end
	end

	assign ent_we = (state_q == S_EVAL) && is_insert && !cur_cut && !cut_now;
	assign ent_waddr = base_q + EA_W'(cur_fill);
	assign ent_raddr = base_q + EA_W'(item_q.slot);

	bkt_ram #(
		.WIDTH(FILL_W + 1),
		.DEPTH(NUM_BUCKETS)
	) u_state_ram (
		.clk(clk),
		.we(st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(q_idx),
		.rdata(st_rdata)
	);

	bkt_ram #(
		.WIDTH(bkt_pkg::ENTRY_W),
		.DEPTH(ENT_DEPTH)
	) u_entry_ram (
		.clk(clk),
		.we(ent_we),
		.waddr(ent_waddr),
		.wdata({item_q.doc_id, item_q.point_id, item_q.quotient}),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_cnt_q <= '0;
			limit_q <= bkt_pkg::LIMIT_RESET;
			item_q <= '0;
			idx_q <= '0;
			base_q <= '0;
			fill_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + IDX_W'(1);
					if (clr_cnt_q == IDX_W'(NUM_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid && q_ready) begin
						item_q <= q_item;
						idx_q <= q_idx;
						base_q <= EA_W'(q_idx) * EA_W'(BUCKET_WAYS);
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					rsp_q.read_doc <= '0;
					rsp_q.read_point <= '0;
					rsp_q.read_quotient <= '0;
					if (is_insert) begin
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
						if (cur_cut) begin
							rsp_q.status <= bkt_pkg::ST_IGNORED;
							rsp_q.fill_count <= bkt_pkg::COUNT_W'(cur_fill);
							rsp_q.is_cut <= 1'b1;
						end else if (cut_now) begin
							rsp_q.status <= bkt_pkg::ST_CUT_NOW;
							rsp_q.fill_count <= '0;
							rsp_q.is_cut <= 1'b1;
						end else begin
							rsp_q.status <= bkt_pkg::ST_STORED;
							rsp_q.fill_count <= bkt_pkg::COUNT_W'(cur_fill + FILL_W'(1));
							rsp_q.is_cut <= 1'b0;
						end
					end else if (slot_hit) begin
						fill_q <= cur_fill;
						state_q <= S_READ;
					end else begin
						rsp_valid_q <= 1'b1;
						rsp_q.status <= bkt_pkg::ST_EMPTY;
						rsp_q.fill_count <= bkt_pkg::COUNT_W'(cur_fill);
						rsp_q.is_cut <= cur_cut;
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					rsp_valid_q <= 1'b1;
					rsp_q.status <= bkt_pkg::ST_READ_OK;
					rsp_q.fill_count <= bkt_pkg::COUNT_W'(fill_q);
					rsp_q.is_cut <= 1'b0;
					rsp_q.read_doc <= ent_rdata[55:24];
					rsp_q.read_point <= ent_rdata[23:8];
					rsp_q.read_quotient <= ent_rdata[7:0];
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/bucket_table_insert_with_overflow_cut.sv
// Top level of the bucketed hash table with collision limit and overflow cut.
// After reset the block sweeps its bucket state memory, one bucket per cycle, over
// all NUM_BUCKETS buckets; req_ready stays low during the sweep while cfg writes are
// taken. Each item then passes a front stage that reduces the bucket index and a
// two-entry queue, and the back end works on one item at a time: an insert or a
// read that misses goes through the bucket state memory read (and, for an insert,
// its write-back), while a read that hits also waits for the entry memory read.
// The result register frees the back end as soon as the result is taken, and the
// front keeps taking items while a result waits, until its stage and queue are full.
module bucket_table_insert_with_overflow_cut #(
	parameter int NUM_BUCKETS = 1024,
	parameter int BUCKET_WAYS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bkt_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic req_valid,
	output logic req_ready,
	input  bkt_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output bkt_pkg::rsp_t rsp
);

	localparam int IDX_W = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;

	logic clearing;
	logic q_valid;
	logic q_ready;
	bkt_pkg::req_t q_item;
	logic [IDX_W-1:0] q_idx;

	bkt_front #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.clearing(clearing),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item),
		.q_idx(q_idx)
	);

	bkt_back #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.BUCKET_WAYS(BUCKET_WAYS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item),
		.q_idx(q_idx),
		.clearing(clearing),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

endmodule

// File: sv/bkt_checker.sv
// Port-level checks of the bucket table results, bound to the top level.
module bkt_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  bkt_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_data_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bkt_pkg::ST_READ_OK |->
		rsp.read_doc == '0 && rsp.read_point == '0 && rsp.read_quotient == '0)
		else $error("entry data on a result that is not a read hit");

	a_cut_empties: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == bkt_pkg::ST_CUT_NOW || rsp.status == bkt_pkg::ST_IGNORED)
		|-> rsp.is_cut && rsp.fill_count == '0)
		else $error("cut bucket not empty");

	a_store_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bkt_pkg::ST_STORED |-> !rsp.is_cut && rsp.fill_count != '0)
		else $error("stored item left bucket cut or empty");

	a_hit_live: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bkt_pkg::ST_READ_OK |-> !rsp.is_cut && rsp.fill_count != '0)
		else $error("read hit on a cut or empty bucket");

endmodule

bind bucket_table_insert_with_overflow_cut bkt_checker u_bkt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp(rsp)
);
